### rtl/aca_pkg.sv
package aca_pkg;

	localparam int FUNC_W  = 2;
	localparam int CHAN_W  = 2;
	localparam int SMP_W   = 12;
	localparam int SUM_W   = 28;
	localparam int CNT_W   = 16;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam int DIV_STEPS = SMP_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [FUNC_W-1:0] FUNC_POLL   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [CNT_W-1:0] AVG_LEN_DEFAULT = 16'd240;

	// register index taken from the word address bit
	localparam logic REG_AVG_LEN = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_PUSH
	} aca_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic push;
	} aca_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} aca_stat_t;

endpackage

### rtl/aca_ctrl.sv
module aca_ctrl import aca_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  aca_stat_t stat,
	output aca_cmd_t  cmd
);

	aca_state_t state_q;
	aca_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_div ? S_DIV : S_PUSH;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				// hold the result until the output register frees up
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/aca_datapath.sv
module aca_datapath import aca_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAN_W-1:0] channel,
	input  logic              data_ready,
	input  logic [SMP_W-1:0]  sample,
	input  logic [CNT_W-1:0]  avg_len,
	input  aca_cmd_t          cmd,
	output aca_stat_t         stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              done_res,
	output logic [SMP_W-1:0]  average
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EXT_W = CH_W + CHAN_W;

	logic [FUNC_W-1:0] func_q;
	logic [CHAN_W-1:0] chan_q;
	logic              ready_q;
	logic [SMP_W-1:0]  sample_q;

	logic [SUM_W-1:0] sum_q [CHANNELS];
	logic [CNT_W-1:0] count_q [CHANNELS];

	logic [EXT_W-1:0] chan_ext;
	logic [CH_W-1:0]  idx;
	logic             ch_ok;

	logic [SUM_W-1:0] cur_sum;
	logic [CNT_W-1:0] cur_cnt;
	logic             cnt_inc;
	logic [SUM_W-1:0] poll_sum;
	logic [CNT_W-1:0] poll_cnt;
	logic             wr_en;
	logic [SUM_W-1:0] wr_sum;
	logic [CNT_W-1:0] wr_cnt;
	logic             done_d;
	logic [SMP_W-1:0] avg_d;
	logic             need_div;

	logic [CNT_W-1:0]       rem_q;
	logic [CNT_W-1:0]       dvs_q;
	logic [SMP_W-1:0]       low_q;
	logic [STEP_W-1:0]      step_q;
	logic [CNT_W:0]         trial;
	logic [CNT_W:0]         diff;
	logic                   ge;

	logic             res_done_q;
	logic [SMP_W-1:0] res_avg_q;
	logic             out_valid_q;
	logic             done_res_q;
	logic [SMP_W-1:0] average_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func;
			chan_q   <= channel;
			ready_q  <= data_ready;
			sample_q <= sample;
		end
	end

	assign chan_ext = {{CH_W{1'b0}}, chan_q};
	assign idx      = chan_ext[CH_W-1:0];
	assign ch_ok    = chan_ext < EXT_W'(CHANNELS);

	always_comb begin
		cur_sum  = ch_ok ? sum_q[idx] : '0;
		cur_cnt  = ch_ok ? count_q[idx] : '0;
		cnt_inc  = ready_q && (cur_cnt != COUNT_MAX);
		poll_cnt = cur_cnt + CNT_W'(cnt_inc);
		poll_sum = cnt_inc ? cur_sum + SUM_W'(sample_q) : cur_sum;

		wr_en    = 1'b0;
		wr_sum   = '0;
		wr_cnt   = '0;
		done_d   = 1'b0;
		avg_d    = '0;
		need_div = 1'b0;
		unique case (func_q)
			FUNC_POLL: begin
				if (ch_ok) begin
					wr_en  = 1'b1;
					wr_sum = poll_sum;
					wr_cnt = poll_cnt;
					done_d = poll_cnt >= avg_len;
				end
			end
			FUNC_READ: begin
				// raw sample unless the divider overwrites it
				avg_d = sample_q;
				if (ch_ok) begin
					wr_en    = 1'b1;
					need_div = cur_cnt != '0;
				end
			end
			FUNC_CANCEL: begin
				wr_en = ch_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]   <= '0;
				count_q[i] <= '0;
			end
		end else if (cmd.exec && wr_en) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (idx == CH_W'(i)) begin
					sum_q[i]   <= wr_sum;
					count_q[i] <= wr_cnt;
				end
			end
		end
	end

	// restoring divide: sum < 4096 * count, so the upper bits start below the divisor
	assign trial = {rem_q, low_q[SMP_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_done_q <= done_d;
			res_avg_q  <= avg_d;
			rem_q      <= cur_sum[SUM_W-1:SMP_W];
			low_q      <= cur_sum[SMP_W-1:0];
			dvs_q      <= cur_cnt;
			step_q     <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			low_q     <= {low_q[SMP_W-2:0], 1'b0};
			res_avg_q <= {res_avg_q[SMP_W-2:0], ge};
			step_q    <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			done_res_q <= res_done_q;
			average_q  <= res_avg_q;
		end
	end

	assign stat.need_div = need_div;
	assign stat.div_last = step_q == STEP_W'(DIV_STEPS - 1);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign done_res  = done_res_q;
	assign average   = average_q;

endmodule

### rtl/adc_channel_averager_unit.sv
// Per-channel boxcar averager for 12-bit converter samples. Each request names a
// channel and an operation: poll (accumulate a ready sample, report done once the
// count reaches average_length), read (sum / count truncated, or the raw sample when
// the count is zero, then clear) or cancel (clear). Poll, cancel, unused codes and
// reads of an empty channel go from acceptance through the execute state to the result
// register; a read of a non-empty channel also passes through the restoring divider,
// which produces one quotient bit per cycle. One request is in flight at a time; the
// next is accepted once the previous result has moved into the output register, which
// holds it until taken. average_length sits at APB address 0 and resets to 240.
module adc_channel_averager_unit import aca_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAN_W-1:0] channel,
	input  logic              data_ready,
	input  logic [SMP_W-1:0]  sample,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              done_res,
	output logic [SMP_W-1:0]  average,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [CNT_W-1:0] avg_len_q;
	logic             reg_sel;
	aca_cmd_t         cmd;
	aca_stat_t        stat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1] == REG_AVG_LEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_len_q <= AVG_LEN_DEFAULT;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			avg_len_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(DATA_W - CNT_W){1'b0}}, avg_len_q} : '0;

	aca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	aca_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (func),
		.channel    (channel),
		.data_ready (data_ready),
		.sample     (sample),
		.avg_len    (avg_len_q),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.done_res   (done_res),
		.average    (average)
	);

endmodule

### rtl/aca_checker.sv
module aca_checker import aca_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             done_res,
	input logic [SMP_W-1:0] average
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(done_res) && $stable(average))
		else $error("result changed while stalled");

	// done comes only from a poll, an average only from a read
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && (average != '0)))
		else $error("result carries both done and average");

	// one request in flight: no acceptance right after an acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

	// a new result appears only while a request is being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a request in flight");

endmodule

bind adc_channel_averager_unit aca_checker u_aca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.done_res  (done_res),
	.average   (average)
);

### tb/tb_adc_channel_averager_unit.sv
`timescale 1ns / 1ps

module tb_adc_channel_averager_unit;
	import aca_pkg::*;

	localparam int CHANNELS = 4;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int PHASES = 8;
	localparam int PHASE_REQS = 250;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic             done;
		logic [SMP_W-1:0] avg;
	} avg_answer_t;

	class avg_scoreboard;
		logic [SUM_W-1:0] acc_sum [CHANNELS];
		logic [CNT_W-1:0] acc_cnt [CHANNELS];
		logic [CNT_W-1:0] avg_len;
		avg_answer_t      pending_answers [$];
		int errors, n_req, n_read, n_done, n_len;

		function new();
			foreach (acc_sum[i]) begin
				acc_sum[i] = '0;
				acc_cnt[i] = '0;
			end
			avg_len = AVG_LEN_DEFAULT;
		endfunction

		function void set_length(logic [CNT_W-1:0] len);
			avg_len = len;
			n_len++;
		endfunction

		// work out the answer of one accepted request and queue it
		function void note_request(logic [FUNC_W-1:0] f, logic [CHAN_W-1:0] ch,
				logic rdy, logic [SMP_W-1:0] smp);
			avg_answer_t ans;
			ans = '0;
			n_req++;
			case (f)
				FUNC_POLL: begin
					if (rdy && acc_cnt[ch] != COUNT_MAX) begin
						acc_sum[ch] = acc_sum[ch] + SUM_W'(smp);
						acc_cnt[ch] = acc_cnt[ch] + 1'b1;
					end
					ans.done = (acc_cnt[ch] >= avg_len);
				end
				FUNC_READ: begin
					n_read++;
					if (acc_cnt[ch] != '0)
						ans.avg = SMP_W'(acc_sum[ch] / SUM_W'(acc_cnt[ch]));
					else
						ans.avg = smp;
					acc_sum[ch] = '0;
					acc_cnt[ch] = '0;
				end
				FUNC_CANCEL: begin
					acc_sum[ch] = '0;
					acc_cnt[ch] = '0;
				end
				default: ;
			endcase
			if (ans.done)
				n_done++;
			pending_answers.push_back(ans);
		endfunction

		function void check_result(logic done, logic [SMP_W-1:0] avg);
			avg_answer_t exp_ans;
			if (pending_answers.size() == 0) begin
				$error("unexpected result: done_res %0d average %0d", done, avg);
				errors++;
				return;
			end
			exp_ans = pending_answers.pop_front();
			if (done !== exp_ans.done) begin
				$error("done_res mismatch: expected %0d, actual %0d", exp_ans.done, done);
				errors++;
			end
			if (avg !== exp_ans.avg) begin
				$error("average mismatch: expected %0d, actual %0d", exp_ans.avg, avg);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [CHAN_W-1:0] channel = '0;
	logic              data_ready = 1'b0;
	logic [SMP_W-1:0]  sample = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              done_res;
	logic [SMP_W-1:0]  average;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	avg_scoreboard board;
	bit src_idle_on = 1'b0;
	bit sink_idle_on = 1'b0;
	int sink_hold = 0;
	int cycles = 0;

	adc_channel_averager_unit #(.CHANNELS(CHANNELS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.channel(channel),
		.data_ready(data_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.done_res(done_res),
		.average(average),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// result side: stall in random bursts while enabled
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold--;
		end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			sink_hold = $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(done_res, average);
	end

	task automatic send_request(logic [FUNC_W-1:0] f, logic [CHAN_W-1:0] ch,
			logic rdy, logic [SMP_W-1:0] smp);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		func       <= f;
		channel    <= ch;
		data_ready <= rdy;
		sample     <= smp;
		do @(posedge clk); while (!in_ready);
		board.note_request(f, ch, rdy, smp);
	endtask

	task automatic send_random_request();
		int pick;
		logic [FUNC_W-1:0] f;
		logic [SMP_W-1:0] smp;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			f = FUNC_POLL;
		else if (pick < 85)
			f = FUNC_READ;
		else if (pick < 95)
			f = FUNC_CANCEL;
		else
			f = FUNC_UNUSED;
		case ($urandom_range(0, 9))
			0: smp = '0;
			1: smp = '1;
			default: smp = SMP_W'($urandom);
		endcase
		send_request(f, CHAN_W'($urandom), $urandom_range(0, 4) != 0, smp);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_answers.size() != 0) @(posedge clk);
	endtask

	// write average_length once the block has gone idle
	task automatic apply_length(logic [CNT_W-1:0] len);
		drain();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_AVG_LEN, 2'b00};
		pwdata  <= {16'($urandom), len};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_length(len);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [CNT_W-1:0] len;
		board = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty reads, extremes, unused code, cancel, short and zero lengths
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		send_request(FUNC_READ, 2'd0, 1'b1, 12'hFFF);
		send_request(FUNC_READ, 2'd1, 1'b0, 12'h000);
		send_request(FUNC_POLL, 2'd0, 1'b1, 12'hFFF);
		send_request(FUNC_POLL, 2'd0, 1'b1, 12'hAAA);
		send_request(FUNC_POLL, 2'd0, 1'b0, 12'h07B);
		send_request(FUNC_POLL, 2'd1, 1'b1, 12'h555);
		send_request(FUNC_UNUSED, 2'd2, 1'b1, 12'hFFF);
		send_request(FUNC_READ, 2'd0, 1'b0, 12'h123);
		send_request(FUNC_POLL, 2'd2, 1'b1, 12'h007);
		send_request(FUNC_CANCEL, 2'd2, 1'b1, 12'hFFF);
		send_request(FUNC_READ, 2'd2, 1'b1, 12'h063);
		send_request(FUNC_CANCEL, 2'd3, 1'b0, 12'h000);
		send_request(FUNC_READ, 2'd1, 1'b1, 12'h800);
		apply_length(16'd1);
		send_request(FUNC_POLL, 2'd3, 1'b1, 12'hFFF);
		send_request(FUNC_POLL, 2'd3, 1'b0, 12'h001);
		send_request(FUNC_READ, 2'd3, 1'b0, 12'h000);
		apply_length(16'd0);
		send_request(FUNC_POLL, 2'd0, 1'b0, 12'h000);
		send_request(FUNC_POLL, 2'd1, 1'b1, 12'h001);
		send_request(FUNC_CANCEL, 2'd1, 1'b0, 12'h000);
		send_request(FUNC_READ, 2'd1, 1'b0, 12'hFFF);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: len = 16'd1;
				1: len = 16'd3;
				2: len = 16'd8;
				3: len = COUNT_MAX;
				4: len = 16'd0;
				5: len = CNT_W'($urandom_range(2, 20));
				6: len = CNT_W'($urandom_range(1, 65535));
				default: len = 16'd16;
			endcase
			apply_length(len);
			for (int i = 0; i < PHASE_REQS; i++) begin
				// switch idling per stretch; the final phase runs flat out
				if (i % 40 == 0) begin
					src_idle_on  = (p < PHASES - 1) && $urandom_range(0, 2) != 0;
					sink_idle_on = (p < PHASES - 1) && $urandom_range(0, 2) != 0;
				end
				send_random_request();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d requests with %0d reads and %0d done reports over %0d lengths.",
			board.n_req, board.n_read, board.n_done, board.n_len);
		$display("Included zero and maximum lengths, empty reads and the unused code.");
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/aca_pkg.sv
rtl/aca_ctrl.sv
rtl/aca_datapath.sv
rtl/adc_channel_averager_unit.sv
rtl/aca_checker.sv
tb/tb_adc_channel_averager_unit.sv
